// File: rtl/rv32i_instruction_decode_defines.svh
// Assertion macros shared by the RV32I instruction decoder RTL.
`ifndef RV32I_INSTRUCTION_DECODE_DEFINES_SVH
`define RV32I_INSTRUCTION_DECODE_DEFINES_SVH

// Checks a condition at every rising edge of clk outside reset.
`define RID_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a trigger implies a consequence in the next cycle, outside reset.
`define RID_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rid_pkg.sv
// Types and constants shared by the RV32I instruction decoder.
package rid_pkg;

  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_IMM    = 7'h13;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_REG    = 7'h33;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_JAL    = 7'h6F;

  localparam logic [6:0] USER_OPCODE_RESET = 7'd11;

  localparam logic [6:0] FUNCT7_BASE = 7'h00;
  localparam logic [6:0] FUNCT7_ALT  = 7'h20;
  localparam logic [5:0] SHIFT_TOP_SRL = 6'h00;
  localparam logic [5:0] SHIFT_TOP_SRA = 6'h10;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_USER    = 2'd1,
    ST_ILLEGAL = 2'd2
  } status_t;

  typedef enum logic [5:0] {
    OP_LUI   = 6'd0,  OP_UPPER_PC = 6'd1,  OP_JAL   = 6'd2,  OP_JALR  = 6'd3,
    OP_BEQ   = 6'd4,  OP_BNE   = 6'd5,  OP_BLT   = 6'd6,  OP_BGE   = 6'd7,
    OP_BLTU  = 6'd8,  OP_BGEU  = 6'd9,  OP_LB    = 6'd10, OP_LH    = 6'd11,
    OP_LW    = 6'd12, OP_LBU   = 6'd13, OP_LHU   = 6'd14, OP_SB    = 6'd15,
    OP_SH    = 6'd16, OP_SW    = 6'd17, OP_ADDI  = 6'd18, OP_SLTI  = 6'd19,
    OP_SLTIU = 6'd20, OP_XORI  = 6'd21, OP_ORI   = 6'd22, OP_ANDI  = 6'd23,
    OP_SLLI  = 6'd24, OP_SRLI  = 6'd25, OP_SRAI  = 6'd26, OP_ADD   = 6'd27,
    OP_SUB   = 6'd28, OP_SLL   = 6'd29, OP_SLT   = 6'd30, OP_SLTU  = 6'd31,
    OP_XOR   = 6'd32, OP_SRL   = 6'd33, OP_SRA   = 6'd34, OP_OR    = 6'd35,
    OP_AND   = 6'd36
  } op_kind_t;

  typedef struct packed {
    logic [31:0] instruction;
    logic [31:0] pc;
    logic [31:0] rs1_value;
    logic [31:0] rs2_value;
  } dec_req_t;

  typedef struct packed {
    status_t     status;
    op_kind_t    op_kind;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [31:0] offset;
    logic [31:0] pc_out;
    logic [4:0]  dest_reg;
  } dec_rsp_t;

endpackage

// File: rtl/rv32i_instruction_decode.sv
// Top level of the RV32I instruction decoder with its request and result registers.

// The decoder takes one request per clock cycle while in_stall is low: the request is
// captured in an input register, decoded by a single pass of combinational logic, and
// written to the result register when the result side does not hold it. The two
// registers let a new instruction enter while the previous result waits, and a stall
// on the result side propagates back to in_stall only when both registers are full.
// The user must write the user-defined major opcode through the cfg port only while
// the decoder is idle; the block itself does not enforce this. It resets to 11 and
// always takes priority over the standard opcodes.
`include "rv32i_instruction_decode_defines.svh"

module rv32i_instruction_decode
  import rid_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dec_req_t in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output dec_rsp_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     [6:0] cfg_data
);

  logic       [6:0] user_opcode_r;
  logic       req_valid_r;
  dec_req_t   req_r;
  logic       out_valid_r;
  dec_rsp_t   out_r;
  dec_rsp_t   out_nxt;
  logic       out_hold;
  logic       req_hold;

  logic [31:0] word;
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  rd;
  logic [5:0]  shift_top;
  logic [31:0] imm_i;
  logic [31:0] imm_u;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] imm_sh;

  logic        cfg_we;
  logic        chk_reject;
  logic        chk_no_dest;

  assign out_hold  = out_valid_r && out_stall;
  assign req_hold  = req_valid_r && out_hold;
  assign in_stall  = req_hold;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  assign word      = req_r.instruction;
  assign opc       = word[6:0];
  assign f3        = word[14:12];
  assign f7        = word[31:25];
  assign rd        = word[11:7];
  assign shift_top = word[31:26];
  assign imm_i     = {{20{word[31]}}, word[31:20]};
  assign imm_u     = {12'd0, word[31:12]};
  assign imm_s     = {{20{word[31]}}, word[31:25], word[11:7]};
  assign imm_b     = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
  assign imm_j     = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
  assign imm_sh    = {26'd0, word[25:20]};

  always_comb begin
    logic     illegal;
    op_kind_t kind;
    dec_rsp_t rsp;
    illegal       = 1'b0;
    kind          = OP_ADD;
    rsp           = '0;
    rsp.pc_out    = req_r.pc;
    case (opc)
      OPC_REG: begin
        rsp.operand_a = req_r.rs1_value;
        rsp.operand_b = req_r.rs2_value;
        rsp.dest_reg  = rd;
        if (f7 == FUNCT7_BASE) begin
          case (f3)
            3'd0:    kind = OP_ADD;
            3'd1:    kind = OP_SLL;
            3'd2:    kind = OP_SLT;
            3'd3:    kind = OP_SLTU;
            3'd4:    kind = OP_XOR;
            3'd5:    kind = OP_SRL;
            3'd6:    kind = OP_OR;
            default: kind = OP_AND;
          endcase
        end else if (f7 == FUNCT7_ALT && f3 == 3'd0) begin
          kind = OP_SUB;
        end else if (f7 == FUNCT7_ALT && f3 == 3'd5) begin
          kind = OP_SRA;
        end else begin
          illegal = 1'b1;
        end
      end
      OPC_IMM: begin
        rsp.operand_a = req_r.rs1_value;
        rsp.operand_b = imm_i;
        rsp.dest_reg  = rd;
        case (f3)
          3'd0:    kind = OP_ADDI;
          3'd1: begin
            kind          = OP_SLLI;
            rsp.operand_b = imm_sh;
          end
          3'd2:    kind = OP_SLTI;
          3'd3:    kind = OP_SLTIU;
          3'd4:    kind = OP_XORI;
          3'd5: begin
            rsp.operand_b = imm_sh;
            if (shift_top == SHIFT_TOP_SRA) begin
              kind = OP_SRAI;
            end else if (shift_top == SHIFT_TOP_SRL) begin
              kind = OP_SRLI;
            end else begin
              illegal = 1'b1;
            end
          end
          3'd6:    kind = OP_ORI;
          default: kind = OP_ANDI;
        endcase
      end
      OPC_LUI, OPC_AUIPC: begin
        kind          = (opc == OPC_LUI) ? OP_LUI : OP_UPPER_PC;
        rsp.operand_a = imm_u;
        rsp.offset    = imm_u;
        rsp.dest_reg  = rd;
      end
      OPC_JAL: begin
        kind          = OP_JAL;
        rsp.operand_a = imm_j;
        rsp.offset    = imm_j;
        rsp.dest_reg  = rd;
      end
      OPC_JALR: begin
        kind          = OP_JALR;
        rsp.operand_a = req_r.rs1_value;
        rsp.operand_b = imm_i;
        rsp.dest_reg  = rd;
      end
      OPC_BRANCH: begin
        rsp.operand_a = req_r.rs1_value;
        rsp.operand_b = req_r.rs2_value;
        rsp.offset    = imm_b;
        case (f3)
          3'd0:    kind = OP_BEQ;
          3'd1:    kind = OP_BNE;
          3'd4:    kind = OP_BLT;
          3'd5:    kind = OP_BGE;
          3'd6:    kind = OP_BLTU;
          3'd7:    kind = OP_BGEU;
          default: illegal = 1'b1;
        endcase
      end
      OPC_STORE: begin
        rsp.operand_a = req_r.rs1_value;
        rsp.operand_b = req_r.rs2_value;
        rsp.offset    = imm_s;
        case (f3)
          3'd0:    kind = OP_SB;
          3'd1:    kind = OP_SH;
          3'd2:    kind = OP_SW;
          default: illegal = 1'b1;
        endcase
      end
      OPC_LOAD: begin
        rsp.operand_a = req_r.rs1_value;
        rsp.operand_b = imm_i;
        rsp.offset    = imm_i;
        rsp.dest_reg  = rd;
        case (f3)
          3'd0:    kind = OP_LB;
          3'd1:    kind = OP_LH;
          3'd2:    kind = OP_LW;
          3'd4:    kind = OP_LBU;
          3'd5:    kind = OP_LHU;
          default: illegal = 1'b1;
        endcase
      end
      default: illegal = 1'b1;
    endcase
    rsp.op_kind = kind;
    rsp.status  = ST_OK;
    if (opc == user_opcode_r) begin
      rsp        = '0;
      rsp.status = ST_USER;
    end else if (illegal) begin
      rsp        = '0;
      rsp.status = ST_ILLEGAL;
    end
    out_nxt = rsp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      user_opcode_r <= USER_OPCODE_RESET;
      req_valid_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        user_opcode_r <= cfg_data;
      end
      if (!req_hold) begin
        req_valid_r <= in_valid;
      end
      if (!out_hold) begin
        out_valid_r <= req_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!req_hold && in_valid) begin
      req_r <= in_data;
    end
    if (!out_hold && req_valid_r) begin
      out_r <= out_nxt;
    end
  end

  assign cfg_we      = cfg_valid && cfg_ready;
  assign chk_reject  = !out_valid_r || (out_r.status == ST_OK) ||
                       ((out_r.operand_a == 32'd0) && (out_r.operand_b == 32'd0) &&
                        (out_r.offset == 32'd0) && (out_r.pc_out == 32'd0) &&
                        (out_r.dest_reg == 5'd0));
  assign chk_no_dest = !out_valid_r || (out_r.status != ST_OK) ||
                       (out_r.dest_reg == 5'd0) ||
                       !(((out_r.op_kind >= OP_BEQ) && (out_r.op_kind <= OP_BGEU)) ||
                         ((out_r.op_kind >= OP_SB) && (out_r.op_kind <= OP_SW)));

  `RID_ASSERT_NEXT(a_req_moves_on, req_valid_r && !out_hold, out_valid_r, "Request lost.")
  `RID_ASSERT_NEXT(a_cfg_written, cfg_we, user_opcode_r == $past(cfg_data), "Config lost.")
  `RID_ASSERT_HOLDS(a_reject_zero, chk_reject, "Rejected result carries fields.")
  `RID_ASSERT_HOLDS(a_no_dest, chk_no_dest, "Branch or store has a destination.")

endmodule

// File: dv/decode_check_pkg.sv
`timescale 1ns / 1ps
// Encoding tables and the result scoreboard for the RV32I decoder testbench.
package decode_check_pkg;
  import rid_pkg::*;

  localparam logic [2:0] F3_ADD_SUB        = 3'd0;
  localparam logic [2:0] F3_SLL            = 3'd1;
  localparam logic [2:0] F3_SR             = 3'd5;
  localparam logic [2:0] F3_BEQ            = 3'd0;
  localparam logic [2:0] F3_BGEU           = 3'd7;
  localparam logic [2:0] F3_BRANCH_UNUSED  = 3'd2;
  localparam logic [2:0] F3_LB             = 3'd0;
  localparam logic [2:0] F3_LHU            = 3'd5;
  localparam logic [2:0] F3_LOAD_UNUSED    = 3'd3;
  localparam logic [2:0] F3_SB             = 3'd0;
  localparam logic [2:0] F3_SW             = 3'd2;
  localparam logic [2:0] F3_STORE_UNUSED   = 3'd3;

  localparam logic [7:0] LOAD_F3_OK   = 8'b0011_0111;
  localparam logic [7:0] STORE_F3_OK  = 8'b0000_0111;
  localparam logic [7:0] BRANCH_F3_OK = 8'b1111_0011;

  localparam op_kind_t REG_OPS [8] = '{OP_ADD, OP_SLL, OP_SLT, OP_SLTU,
                                       OP_XOR, OP_SRL, OP_OR, OP_AND};
  localparam op_kind_t IMM_OPS [8] = '{OP_ADDI, OP_SLLI, OP_SLTI, OP_SLTIU,
                                       OP_XORI, OP_SRLI, OP_ORI, OP_ANDI};
  localparam op_kind_t LOAD_OPS [8] = '{OP_LB, OP_LH, OP_LW, OP_LB,
                                        OP_LBU, OP_LHU, OP_LB, OP_LB};
  localparam op_kind_t STORE_OPS [8] = '{OP_SB, OP_SH, OP_SW, OP_SB,
                                         OP_SB, OP_SB, OP_SB, OP_SB};
  localparam op_kind_t BRANCH_OPS [8] = '{OP_BEQ, OP_BNE, OP_BEQ, OP_BEQ,
                                          OP_BLT, OP_BGE, OP_BLTU, OP_BGEU};

  localparam logic [6:0] STD_OPCODES [9] = '{OPC_LOAD, OPC_IMM, OPC_AUIPC, OPC_STORE,
                                             OPC_REG, OPC_LUI, OPC_BRANCH, OPC_JALR,
                                             OPC_JAL};

  localparam int REPORT_LIMIT = 10;

  class decode_scoreboard;
    logic [6:0] user_opcode = USER_OPCODE_RESET;
    dec_rsp_t expected_decodes [$];
    int unsigned mismatch_count = 0;
    int unsigned checked_count = 0;
    int unsigned status_counts [3] = '{0, 0, 0};
    bit [36:0] kinds_seen = '0;

    function void set_user_opcode(logic [6:0] value);
      user_opcode = value;
    endfunction

    function int pending();
      return expected_decodes.size();
    endfunction

    function dec_rsp_t decode_word(dec_req_t req);
      logic [31:0] w;
      logic [31:0] imm_i;
      logic [31:0] imm_u;
      logic [31:0] imm_s;
      logic [31:0] imm_b;
      logic [31:0] imm_j;
      logic [6:0] opc;
      logic [2:0] f3;
      logic [6:0] f7;
      logic legal;
      dec_rsp_t d;
      w = req.instruction;
      opc = w[6:0];
      f3 = w[14:12];
      f7 = w[31:25];
      imm_i = {{20{w[31]}}, w[31:20]};
      imm_u = {12'b0, w[31:12]};
      imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
      imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      d = '0;
      d.status = ST_OK;
      d.pc_out = req.pc;
      legal = 1'b1;
      if (opc == user_opcode) begin
        d = '0;
        d.status = ST_USER;
        return d;
      end
      case (opc)
        OPC_REG: begin
          d.operand_a = req.rs1_value;
          d.operand_b = req.rs2_value;
          d.dest_reg = w[11:7];
          if (f7 == FUNCT7_BASE) d.op_kind = REG_OPS[f3];
          else if (f7 == FUNCT7_ALT && f3 == F3_ADD_SUB) d.op_kind = OP_SUB;
          else if (f7 == FUNCT7_ALT && f3 == F3_SR) d.op_kind = OP_SRA;
          else legal = 1'b0;
        end
        OPC_IMM: begin
          d.op_kind = IMM_OPS[f3];
          d.operand_a = req.rs1_value;
          d.operand_b = imm_i;
          d.dest_reg = w[11:7];
          if (f3 == F3_SLL) begin
            d.operand_b = {26'b0, w[25:20]};
          end else if (f3 == F3_SR) begin
            d.operand_b = {26'b0, w[25:20]};
            if (w[31:26] == SHIFT_TOP_SRA) d.op_kind = OP_SRAI;
            else if (w[31:26] != SHIFT_TOP_SRL) legal = 1'b0;
          end
        end
        OPC_LUI, OPC_AUIPC: begin
          d.op_kind = (opc == OPC_LUI) ? OP_LUI : OP_UPPER_PC;
          d.operand_a = imm_u;
          d.offset = imm_u;
          d.dest_reg = w[11:7];
        end
        OPC_JAL: begin
          d.op_kind = OP_JAL;
          d.operand_a = imm_j;
          d.offset = imm_j;
          d.dest_reg = w[11:7];
        end
        OPC_JALR: begin
          d.op_kind = OP_JALR;
          d.operand_a = req.rs1_value;
          d.operand_b = imm_i;
          d.dest_reg = w[11:7];
        end
        OPC_BRANCH: begin
          d.op_kind = BRANCH_OPS[f3];
          legal = BRANCH_F3_OK[f3];
          d.operand_a = req.rs1_value;
          d.operand_b = req.rs2_value;
          d.offset = imm_b;
        end
        OPC_STORE: begin
          d.op_kind = STORE_OPS[f3];
          legal = STORE_F3_OK[f3];
          d.operand_a = req.rs1_value;
          d.operand_b = req.rs2_value;
          d.offset = imm_s;
        end
        OPC_LOAD: begin
          d.op_kind = LOAD_OPS[f3];
          legal = LOAD_F3_OK[f3];
          d.operand_a = req.rs1_value;
          d.operand_b = imm_i;
          d.offset = imm_i;
          d.dest_reg = w[11:7];
        end
        default: legal = 1'b0;
      endcase
      if (!legal) begin
        d = '0;
        d.status = ST_ILLEGAL;
      end
      return d;
    endfunction

    function void note_request(dec_req_t req);
      expected_decodes.push_back(decode_word(req));
    endfunction

    function string describe(dec_rsp_t d);
      return $sformatf("status=%0d op=%0d a=%h b=%h off=%h pc=%h rd=%0d", d.status,
                       d.op_kind, d.operand_a, d.operand_b, d.offset, d.pc_out, d.dest_reg);
    endfunction

    function void check_result(dec_rsp_t got);
      dec_rsp_t want;
      bit bad;
      if (expected_decodes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("decode result with no request outstanding: %s", describe(got));
        return;
      end
      want = expected_decodes.pop_front();
      bad = (got.status !== want.status) || (got.op_kind !== want.op_kind) ||
            (got.operand_a !== want.operand_a) || (got.operand_b !== want.operand_b) ||
            (got.offset !== want.offset) || (got.pc_out !== want.pc_out) ||
            (got.dest_reg !== want.dest_reg);
      if (bad) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("decode mismatch expected: %s", describe(want));
          $display("decode mismatch actual:   %s", describe(got));
        end
      end else begin
        checked_count++;
        status_counts[got.status]++;
        if (got.status == ST_OK) kinds_seen[got.op_kind] = 1'b1;
      end
    endfunction
  endclass

endpackage

// File: dv/tb.sv
`timescale 1ns / 1ps
// Top-level testbench that drives the RV32I decoder and checks every result.
module tb;
  import rid_pkg::*;
  import decode_check_pkg::*;

  localparam int RESET_CYCLES = 10;
  localparam int NUM_PHASES = 5;
  localparam int PHASE_ITEMS = 320;
  localparam int CALM_PHASE = 1;
  localparam int HOLD_PHASE = 2;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam int IDLE_PERCENT = 22;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  dec_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  dec_rsp_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [6:0] cfg_data = '0;

  logic calm = 1'b0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  decode_scoreboard sb = new;

  rv32i_instruction_decode dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run exceeded %0d cycles with %0d decodes outstanding.", CYCLE_LIMIT,
               sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (hold_left != 0) out_stall <= 1'b1;
    else if (calm) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < IDLE_PERCENT);
  end

  function automatic logic [31:0] rtype_word(logic [6:0] f7, logic [4:0] rs2,
                                             logic [4:0] rs1, logic [2:0] f3,
                                             logic [4:0] rd, logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic dec_req_t make_request(logic [31:0] word);
    dec_req_t r;
    r.instruction = word;
    r.pc = pick_value();
    r.rs1_value = pick_value();
    r.rs2_value = pick_value();
    return r;
  endfunction

  // Mostly well-formed instructions with random fields; a share of raw noise,
  // user-defined words and words with broken function fields.
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    int unsigned pick;
    bit broken;
    w = $urandom();
    pick = $urandom_range(99);
    broken = ($urandom_range(9) == 0);
    if (pick < 6) return w;
    if (pick < 12) begin
      w[6:0] = sb.user_opcode;
      return w;
    end
    w[6:0] = STD_OPCODES[$urandom_range(8)];
    if (broken) return w;
    case (w[6:0])
      OPC_REG: begin
        if ($urandom_range(3) == 0) begin
          w[31:25] = FUNCT7_ALT;
          w[14:12] = $urandom_range(1) ? F3_SR : F3_ADD_SUB;
        end else begin
          w[31:25] = FUNCT7_BASE;
        end
      end
      OPC_IMM: begin
        if (w[14:12] == F3_SR) w[31:26] = $urandom_range(1) ? SHIFT_TOP_SRA : SHIFT_TOP_SRL;
      end
      OPC_LOAD: while (!LOAD_F3_OK[w[14:12]]) w[14:12] = 3'($urandom_range(7));
      OPC_STORE: while (!STORE_F3_OK[w[14:12]]) w[14:12] = 3'($urandom_range(7));
      OPC_BRANCH: while (!BRANCH_F3_OK[w[14:12]]) w[14:12] = 3'($urandom_range(7));
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_request(input dec_req_t r);
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
  endtask

  task automatic sender_gap();
    if (calm) return;
    while ($urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_decoder();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_user_opcode(input logic [6:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_user_opcode(value);
  endtask

  initial begin
    logic [31:0] directed [$];
    logic [6:0] settings [NUM_PHASES];
    settings = '{7'h7F, 7'h00, OPC_IMM, 7'h00, USER_OPCODE_RESET};
    settings[3] = 7'($urandom_range(127));
    directed = {
      32'h0000_0000, 32'hFFFF_FFFF,
      rtype_word(7'h7F, 5'h1F, 5'h1F, 3'h7, 5'h1F, USER_OPCODE_RESET),
      rtype_word(7'h7F, 5'h1F, 5'h1F, 3'h7, 5'h1F, OPC_LUI),
      rtype_word(7'h00, 5'h00, 5'h00, 3'h0, 5'h01, OPC_AUIPC),
      rtype_word(7'h7F, 5'h1F, 5'h1F, 3'h7, 5'h1F, OPC_JAL),
      rtype_word(7'h3F, 5'h1F, 5'h1F, 3'h7, 5'h01, OPC_JAL),
      rtype_word(7'h40, 5'h00, 5'h1F, 3'h0, 5'h1F, OPC_JALR),
      rtype_word(7'h7F, 5'h1F, 5'h1F, F3_BEQ, 5'h1F, OPC_BRANCH),
      rtype_word(7'h3F, 5'h1F, 5'h00, F3_BGEU, 5'h1E, OPC_BRANCH),
      rtype_word(7'h40, 5'h00, 5'h01, F3_LB, 5'h1F, OPC_LOAD),
      rtype_word(7'h3F, 5'h1F, 5'h1F, F3_LHU, 5'h00, OPC_LOAD),
      rtype_word(7'h7F, 5'h00, 5'h1F, F3_SW, 5'h1F, OPC_STORE),
      rtype_word(7'h3F, 5'h1F, 5'h00, F3_SB, 5'h1F, OPC_STORE),
      rtype_word(FUNCT7_BASE, 5'h1F, 5'h1F, F3_ADD_SUB, 5'h1F, OPC_REG),
      rtype_word(FUNCT7_ALT, 5'h00, 5'h00, F3_ADD_SUB, 5'h01, OPC_REG),
      rtype_word(FUNCT7_ALT, 5'h1F, 5'h1F, F3_SR, 5'h1F, OPC_REG),
      rtype_word(FUNCT7_ALT, 5'h01, 5'h01, F3_SLL, 5'h01, OPC_REG),
      rtype_word(7'h01, 5'h00, 5'h00, F3_ADD_SUB, 5'h00, OPC_REG),
      rtype_word(7'h7F, 5'h1F, 5'h1F, F3_SLL, 5'h1F, OPC_IMM),
      rtype_word({SHIFT_TOP_SRA, 1'b1}, 5'h1F, 5'h1F, F3_SR, 5'h1F, OPC_IMM),
      rtype_word({SHIFT_TOP_SRL, 1'b1}, 5'h00, 5'h1F, F3_SR, 5'h01, OPC_IMM),
      rtype_word(7'h02, 5'h1F, 5'h1F, F3_SR, 5'h1F, OPC_IMM),
      rtype_word(7'h00, 5'h00, 5'h00, F3_LOAD_UNUSED, 5'h01, OPC_LOAD),
      rtype_word(7'h00, 5'h00, 5'h00, F3_STORE_UNUSED, 5'h01, OPC_STORE),
      rtype_word(7'h00, 5'h00, 5'h00, F3_BRANCH_UNUSED, 5'h01, OPC_BRANCH)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      sender_gap();
      send_request(make_request(directed[i]));
    end

    // Each phase runs under a new opcode setting; one phase has no idling and
    // another opens with a long hold on the result side.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_decoder();
      write_user_opcode(settings[p]);
      calm <= (p == CALM_PHASE);
      if (p == HOLD_PHASE) hold_go <= 1'b1;
      repeat (PHASE_ITEMS) begin
        sender_gap();
        send_request(make_request(random_word()));
      end
    end

    drain_decoder();
    $display("Checked %0d decodes: %0d decoded, %0d user-defined, %0d illegal.",
             sb.checked_count, sb.status_counts[ST_OK], sb.status_counts[ST_USER],
             sb.status_counts[ST_ILLEGAL]);
    $display("Saw %0d of 37 operation kinds over %0d opcode settings and a %0d-cycle hold.",
             $countones(sb.kinds_seen), NUM_PHASES + 1, HOLD_CYCLES);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d decodes never delivered.", sb.mismatch_count,
               sb.pending());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
